>>> rtl/fhcc_pkg.sv
package fhcc_pkg;

    localparam int MAX_FRAME_BYTES = 8192;
    localparam int COUNT_W         = 14;
    localparam int COUNT_CAP_I     = (MAX_FRAME_BYTES < 16383) ? MAX_FRAME_BYTES : 16383;
    localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(COUNT_CAP_I);

    localparam int HDR_BYTES   = 4;
    localparam int TRAILER_LEN = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  WINDOW_MASK = 8'b0001_1111;
    localparam logic [7:0]  TYPE_MASK   = 8'b1110_0000;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFF_FFFF;

    localparam logic [12:0] MAX_PAYLOAD_RST = 13'd512;
    localparam logic [4:0]  MAX_WINDOW_RST  = 5'd31;
    localparam logic [2:0]  DATA_TYPE_RST   = 3'd1;
    localparam logic [2:0]  ACK_TYPE_RST    = 3'd2;
    localparam logic [2:0]  NACK_TYPE_RST   = 3'd3;

    typedef enum logic [2:0] {
        CFG_MAX_PAYLOAD = 3'd0,
        CFG_MAX_WINDOW  = 3'd1,
        CFG_DATA_TYPE   = 3'd2,
        CFG_ACK_TYPE    = 3'd3,
        CFG_NACK_TYPE   = 3'd4
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_HEADER  = 3'd1,
        ST_BAD_TYPE   = 3'd2,
        ST_BAD_LENGTH = 3'd3,
        ST_BAD_WINDOW = 3'd4,
        ST_CRC_ERROR  = 3'd5,
        ST_NO_PAYLOAD = 3'd6
    } t_frame_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_item_kind;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_end;
    } t_in_item;

    typedef struct packed {
        t_item_kind    item_kind;
        logic [7:0]    payload_byte;
        logic [2:0]    frame_type;
        logic [4:0]    win_size;
        logic [7:0]    sequence_number;
        logic [15:0]   payload_length;
        logic [31:0]   received_crc;
        t_frame_status frame_status;
        logic          run_last;
    } t_out_item;

    typedef struct packed {
        logic          has_pay;
        logic [7:0]    pay_byte;
        logic          has_stat;
        logic [2:0]    frame_type;
        logic [4:0]    win_size;
        logic [7:0]    sequence_number;
        logic [15:0]   payload_length;
        logic [31:0]   received_crc;
        t_frame_status frame_status;
    } t_entry;

    function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

>>> rtl/frame_header_crc_checker_core.sv
// Frame header and CRC-32 checker.
// Input channel: one frame byte per transfer (i_in_valid / o_in_stall), with
// frame_end set on the last byte of a frame. Output channel (o_out_valid /
// i_out_stall): payload bytes forwarded cut-through (item_kind 0) and one
// status item at the end of each frame (item_kind 1) carrying the header
// fields, the received trailer and the check result.
// A payload byte is forwarded when the byte four positions after it arrives;
// the entry is written into the queue and then into the output register that
// drives o_out_valid. A status item follows the last byte the same way,
// behind the payload byte when one goes out first.
// Throughput: one input byte per cycle while o_in_stall is low. The last byte
// of a frame can produce two results; a four-entry queue between the parsing
// front end and the output stage absorbs the extra item, so a full line rate
// is kept between frames. When the receiver stalls, the output item holds, the
// queue fills, and o_in_stall rises once the queue is full.
// Reset clears the frame state, the queue and the output valid flag, and loads
// the default configuration. Configuration writes (i_cfg_we, i_cfg_index,
// i_cfg_data) take effect at once; write them only while the block is idle.
module frame_header_crc_checker_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [12:0]         i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fhcc_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fhcc_pkg::t_out_item o_out
);

    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;
    fhcc_pkg::t_entry entry;
    fhcc_pkg::t_entry head;

    fhcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_in_stall  (o_in_stall),
        .o_push      (push),
        .o_entry     (entry)
    );

    fhcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head)
    );

    fhcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

>>> rtl/fhcc_front.sv
module fhcc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [12:0]       i_cfg_data,
    input  logic              i_in_valid,
    input  fhcc_pkg::t_in_item i_in,
    input  logic              i_q_full,
    output logic              o_in_stall,
    output logic              o_push,
    output fhcc_pkg::t_entry  o_entry
);

    logic [12:0] r_max_payload;
    logic [4:0]  r_max_window;
    logic [2:0]  r_data_type;
    logic [2:0]  r_ack_type;
    logic [2:0]  r_nack_type;

    logic [7:0]                   r_meta, n_meta;
    logic [7:0]                   r_seq, n_seq;
    logic [15:0]                  r_len, n_len;
    logic [fhcc_pkg::COUNT_W-1:0] r_count, n_count;
    logic [31:0]                  r_crc, n_crc;
    logic [7:0]                   r_delay [fhcc_pkg::TRAILER_LEN];

    logic        accept;
    logic [7:0]  b;
    logic [2:0]  ty;
    logic [4:0]  wi;
    logic [31:0] rc;
    logic        has_pay;
    fhcc_pkg::t_frame_status st;

    assign b          = i_in.frame_byte;
    assign accept     = i_in_valid && !i_q_full;
    assign o_in_stall = i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_payload <= fhcc_pkg::MAX_PAYLOAD_RST;
            r_max_window  <= fhcc_pkg::MAX_WINDOW_RST;
            r_data_type   <= fhcc_pkg::DATA_TYPE_RST;
            r_ack_type    <= fhcc_pkg::ACK_TYPE_RST;
            r_nack_type   <= fhcc_pkg::NACK_TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                fhcc_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                fhcc_pkg::CFG_MAX_WINDOW:  r_max_window  <= i_cfg_data[4:0];
                fhcc_pkg::CFG_DATA_TYPE:   r_data_type   <= i_cfg_data[2:0];
                fhcc_pkg::CFG_ACK_TYPE:    r_ack_type    <= i_cfg_data[2:0];
                fhcc_pkg::CFG_NACK_TYPE:   r_nack_type   <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_meta = (r_count == fhcc_pkg::COUNT_W'(0)) ? b : r_meta;
        n_seq  = (r_count == fhcc_pkg::COUNT_W'(1)) ? b : r_seq;
        n_len  = r_len;
        if (r_count == fhcc_pkg::COUNT_W'(2)) begin
            n_len = {b, r_len[7:0]};
        end else if (r_count == fhcc_pkg::COUNT_W'(3)) begin
            n_len = {r_len[15:8], b};
        end

        // fold the byte leaving the delay line
        n_crc = r_crc;
        if (r_count >= fhcc_pkg::COUNT_W'(fhcc_pkg::HDR_BYTES)) begin
            n_crc = fhcc_pkg::crc32_byte(r_crc, r_delay[3]);
        end

        has_pay = (r_count >= fhcc_pkg::COUNT_W'(8)) && (r_count < fhcc_pkg::COUNT_CAP)
                  && ((16'(r_count) - 16'd8) < r_len);

        n_count = (r_count < fhcc_pkg::COUNT_CAP) ? r_count + fhcc_pkg::COUNT_W'(1) : r_count;

        ty = 3'((n_meta & fhcc_pkg::TYPE_MASK) >> 5);
        wi = 5'(n_meta & fhcc_pkg::WINDOW_MASK);
        rc = {r_delay[2], r_delay[1], r_delay[0], b};

        if (n_count < fhcc_pkg::COUNT_W'(4)) begin
            st = fhcc_pkg::ST_NO_HEADER;
        end else if (ty != r_data_type && ty != r_ack_type && ty != r_nack_type) begin
            st = fhcc_pkg::ST_BAD_TYPE;
        end else if (n_len > 16'(r_max_payload)) begin
            st = fhcc_pkg::ST_BAD_LENGTH;
        end else if (wi > r_max_window) begin
            st = fhcc_pkg::ST_BAD_WINDOW;
        end else if (~n_crc != rc) begin
            st = fhcc_pkg::ST_CRC_ERROR;
        end else if (ty != r_data_type) begin
            st = (n_count == fhcc_pkg::COUNT_W'(8)) ? fhcc_pkg::ST_OK : fhcc_pkg::ST_BAD_LENGTH;
        end else if (n_len == 16'd0) begin
            st = fhcc_pkg::ST_NO_PAYLOAD;
        end else if (17'(n_count) < (17'(n_len) + 17'd8)) begin
            st = (n_count == fhcc_pkg::COUNT_W'(8)) ? fhcc_pkg::ST_NO_PAYLOAD
                                                   : fhcc_pkg::ST_BAD_LENGTH;
        end else begin
            st = fhcc_pkg::ST_OK;
        end

        o_entry.has_pay         = has_pay;
        o_entry.pay_byte        = r_delay[3];
        o_entry.has_stat        = i_in.frame_end;
        o_entry.frame_type      = ty;
        o_entry.win_size        = wi;
        o_entry.sequence_number = n_seq;
        o_entry.payload_length  = n_len;
        o_entry.received_crc    = rc;
        o_entry.frame_status    = st;
        o_push = accept && (has_pay || i_in.frame_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in.frame_end)) begin
            r_meta  <= '0;
            r_seq   <= '0;
            r_len   <= '0;
            r_count <= '0;
            r_crc   <= fhcc_pkg::CRC_INIT;
            r_delay <= '{default: '0};
        end else if (accept) begin
            r_meta     <= n_meta;
            r_seq      <= n_seq;
            r_len      <= n_len;
            r_count    <= n_count;
            r_crc      <= n_crc;
            r_delay[3] <= r_delay[2];
            r_delay[2] <= r_delay[1];
            r_delay[1] <= r_delay[0];
            r_delay[0] <= b;
        end
    end

endmodule

>>> rtl/fhcc_queue.sv
module fhcc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fhcc_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output fhcc_pkg::t_entry o_head
);

    fhcc_pkg::t_entry r_mem [fhcc_pkg::QUEUE_DEPTH];

    logic [fhcc_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [fhcc_pkg::QCNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == fhcc_pkg::QCNT_W'(fhcc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + fhcc_pkg::QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - fhcc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + fhcc_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + fhcc_pkg::QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fhcc_pkg::QCNT_W'(fhcc_pkg::QUEUE_DEPTH))
        else $error("queue count overflow");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || o_full) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

>>> rtl/fhcc_back.sv
module fhcc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  fhcc_pkg::t_entry    i_head,
    output logic                o_pop,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output fhcc_pkg::t_out_item o_out
);

    logic                r_out_valid, n_out_valid;
    fhcc_pkg::t_out_item r_out, n_out;
    logic                r_pay_done, n_pay_done;
    logic                load;
    logic                emit_pay;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        load        = !r_out_valid || !i_out_stall;
        emit_pay    = i_head.has_pay && !r_pay_done;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_pay_done  = r_pay_done;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = i_q_valid;
            if (i_q_valid) begin
                if (emit_pay) begin
                    n_out              = '0;
                    n_out.item_kind    = fhcc_pkg::KIND_PAYLOAD;
                    n_out.payload_byte = i_head.pay_byte;
                    n_out.run_last     = !i_head.has_stat;
                    n_pay_done         = i_head.has_stat;
                    o_pop              = !i_head.has_stat;
                end else begin
                    n_out.item_kind       = fhcc_pkg::KIND_STATUS;
                    n_out.payload_byte    = '0;
                    n_out.frame_type      = i_head.frame_type;
                    n_out.win_size        = i_head.win_size;
                    n_out.sequence_number = i_head.sequence_number;
                    n_out.payload_length  = i_head.payload_length;
                    n_out.received_crc    = i_head.received_crc;
                    n_out.frame_status    = i_head.frame_status;
                    n_out.run_last        = 1'b1;
                    n_pay_done            = 1'b0;
                    o_pop                 = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pay_done  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pay_done  <= n_pay_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    a_split_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pay_done |-> (i_q_valid && i_head.has_stat))
        else $error("payload half sent without pending status");

    a_payload_then_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.item_kind == fhcc_pkg::KIND_PAYLOAD && !r_out.run_last)
        |-> r_pay_done)
        else $error("payload without run_last but no status queued");

endmodule
